// ----- sv/scs_pkg.sv -----
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types, constants and helpers for the case-insensitive substring
// search block.
// ----------------------------------------------------------------------------
package scs_pkg;

  // default pattern capacity in bytes
  localparam int PATTERN_MAX = 16;

  // command codes carried by cmd_i
  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_TEXT    = 1'b1;

  // one result word
  typedef struct packed {
    logic found;
    logic pattern_too_long;
  } res_t;

  // ascii upper case to lower case, everything else unchanged
  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

// ----- sv/case_insensitive_substring_search.sv -----
// A text word with last goes through the input register, then the result register.
// Throughput: one word per cycle; the window compare against the pattern
// store finishes in the cycle a word leaves the input register.
// The input register stalls only while a finished result waits on out_ready_i.
// Reset: asynchronous, active low; empty pattern, empty run, no result pending.
// ----------------------------------------------------------------------------
// case_insensitive_substring_search
// Streaming matcher: loads a folded pattern, then reports per text run
// whether the pattern occurred anywhere in it, or that the pattern overflowed.
// ----------------------------------------------------------------------------
module case_insensitive_substring_search #(
  parameter int PatternMax = scs_pkg::PATTERN_MAX
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       found_o,
  output logic       pattern_too_long_o
);

  logic          s_valid_q;
  logic          s_cmd_q;
  logic [7:0]    s_byte_q;
  logic          s_last_q;
  logic          s_gives_res;
  logic          res_free;
  logic          adv;
  logic          out_valid_q;
  scs_pkg::res_t res_q;
  scs_pkg::res_t core_res;

  assign s_gives_res = (s_cmd_q == scs_pkg::CMD_TEXT) & s_last_q;
  assign res_free    = ~out_valid_q | out_ready_i;
  assign adv         = s_valid_q & (~s_gives_res | res_free);
  assign in_ready_o  = ~s_valid_q | adv;

  scs_core #(
    .PatternMax(PatternMax)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (adv),
    .cmd_i      (s_cmd_q),
    .data_byte_i(s_byte_q),
    .last_i     (s_last_q),
    .result_o   (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s_valid_q <= in_valid_i;
      end
      if (adv && s_gives_res) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s_cmd_q  <= cmd_i;
      s_byte_q <= data_byte_i;
      s_last_q <= last_i;
    end
    if (adv && s_gives_res) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign found_o            = res_q.found;
  assign pattern_too_long_o = res_q.pattern_too_long;

endmodule

// ----- sv/scs_core.sv -----
// ----------------------------------------------------------------------------
// scs_core
// Pattern store, text window and combinational window compare. State advances
// on step_i; result_o is valid in the same cycle for a text word with last.
// ----------------------------------------------------------------------------
module scs_core #(
  parameter int PatternMax = scs_pkg::PATTERN_MAX
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               cmd_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_i,
  output scs_pkg::res_t      result_o
);

  localparam int LW = $clog2(PatternMax + 1);
  localparam logic [LW-1:0] FullCount = LW'(PatternMax);

  // pattern held newest byte first so it lines up with the window
  logic [7:0]    pat_q [PatternMax];
  logic [7:0]    pat_d [PatternMax];
  logic [7:0]    win_q [PatternMax];
  logic [7:0]    win_d [PatternMax];
  logic [LW-1:0] plen_q, plen_d;
  logic          pcomplete_q, pcomplete_d;
  logic          povf_q, povf_d;
  logic [LW-1:0] tcount_q, tcount_d;
  logic          found_q, found_d;

  always_comb begin
    logic [7:0]    b;
    logic [LW-1:0] len_base;
    logic          ovf_base;
    logic          hit;
    logic          found_now;
    logic [LW-1:0] tcount_inc;

    b           = scs_pkg::fold_byte(data_byte_i);
    pat_d       = pat_q;
    win_d       = win_q;
    plen_d      = plen_q;
    pcomplete_d = pcomplete_q;
    povf_d      = povf_q;
    tcount_d    = tcount_q;
    found_d     = found_q;
    result_o    = '0;

    len_base    = pcomplete_q ? '0 : plen_q;
    ovf_base    = pcomplete_q ? 1'b0 : povf_q;

    win_d[0] = b;
    for (int i = 1; i < PatternMax; i++) begin
      win_d[i] = win_q[i-1];
    end
    tcount_inc = (tcount_q < FullCount) ? tcount_q + 1'b1 : tcount_q;

    // compare the shifted window against the stored pattern
    hit = (tcount_inc >= plen_q);
    for (int i = 0; i < PatternMax; i++) begin
      if (LW'(i) < plen_q && win_d[i] != pat_q[i]) begin
        hit = 1'b0;
      end
    end
    found_now = found_q | hit;

    if (step_i) begin
      if (cmd_i == scs_pkg::CMD_PATTERN) begin
        win_d  = win_q;
        povf_d = ovf_base;
        plen_d = len_base;
        if (len_base < FullCount) begin
          pat_d[0] = b;
          for (int i = 1; i < PatternMax; i++) begin
            pat_d[i] = pat_q[i-1];
          end
          plen_d = len_base + 1'b1;
        end else begin
          povf_d = 1'b1;
        end
        pcomplete_d = last_i;
      end else begin
        if (last_i) begin
          result_o.found            = found_now & ~povf_q;
          result_o.pattern_too_long = povf_q;
          tcount_d = '0;
          found_d  = 1'b0;
        end else begin
          tcount_d = tcount_inc;
          found_d  = found_now;
        end
      end
    end else begin
      win_d = win_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q      <= '0;
      pcomplete_q <= 1'b1;
      povf_q      <= 1'b0;
      tcount_q    <= '0;
      found_q     <= 1'b0;
    end else begin
      plen_q      <= plen_d;
      pcomplete_q <= pcomplete_d;
      povf_q      <= povf_d;
      tcount_q    <= tcount_d;
      found_q     <= found_d;
    end
  end

  // entries past the counts are masked, so the arrays need no reset
  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
    win_q <= win_d;
  end

endmodule

// ----- sv/scs_checker.sv -----
// ----------------------------------------------------------------------------
// scs_checker
// Port-level checks for the substring search block, bound to the top level.
// ----------------------------------------------------------------------------
module scs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       cmd_i,
  input logic [7:0] data_byte_i,
  input logic       last_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       found_o,
  input logic       pattern_too_long_o
);

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(found_o) && $stable(pattern_too_long_o))
    else $error("result word changed while stalled");

  // a truncated pattern never reports a match
  a_ovf_no_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pattern_too_long_o |-> !found_o)
    else $error("found with truncated pattern");

  // with the output side empty the input side never stalls
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no result pending");

endmodule

bind case_insensitive_substring_search scs_checker u_scs_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .cmd_i             (cmd_i),
  .data_byte_i       (data_byte_i),
  .last_i            (last_i),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .found_o           (found_o),
  .pattern_too_long_o(pattern_too_long_o)
);
